// ===== sv/accel_step_detector_top_macros.svh =====
`ifndef ACCEL_STEP_DETECTOR_TOP_MACROS_SVH
`define ACCEL_STEP_DETECTOR_TOP_MACROS_SVH

// check that holds in the same cycle as the trigger
`define ASD_ASSERT_NOW(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
    else $error(msg);

// check that holds in the cycle after the trigger
`define ASD_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error(msg);

`endif

// ===== sv/asd_pkg.sv =====
`default_nettype none

package asd_pkg;

  // magnitude and datapath widths
  localparam int MAG_W      = 16;
  localparam int ACC_W      = 32;
  localparam int REM_W      = 17;
  localparam int MUL_W      = 18;
  localparam int ROOT_STEPS = 16;

  // register file addressing
  localparam int REG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_STEP_MARGIN     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MIN_INTERVAL_MS = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TILT_IDLE_BELOW = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TILT_BAND_LOW   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TILT_BAND_HIGH  = 3'd4;

  // level codes
  localparam logic [1:0] LEVEL_IDLE   = 2'd0;
  localparam logic [1:0] LEVEL_SINGLE = 2'd1;
  localparam logic [1:0] LEVEL_BOTH   = 2'd2;

  typedef struct packed {
    logic               command;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [31:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic [31:0] step_count;
    logic        step_seen;
    logic        window_ready;
    logic        led_green;
    logic        led_red;
    logic [1:0]  level_code;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        step_margin;
    logic [15:0]        min_interval_ms;
    logic signed [15:0] tilt_idle_below;
    logic signed [15:0] tilt_band_low;
    logic signed [15:0] tilt_band_high;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    step_margin:     16'd1597,
    min_interval_ms: 16'd400,
    tilt_idle_below: 16'sd1,
    tilt_band_low:   16'sd2048,
    tilt_band_high:  16'sd2253
  };

endpackage

`default_nettype wire

// ===== sv/asd_regs.sv =====
`default_nettype none

module asd_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [asd_pkg::REG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  output asd_pkg::cfg_t                       cfg
);
  import asd_pkg::*;

  cfg_t                 cfg_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[REG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  // register writes in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_STEP_MARGIN:     cfg_r.step_margin     <= pwdata[15:0];
        REG_MIN_INTERVAL_MS: cfg_r.min_interval_ms <= pwdata[15:0];
        REG_TILT_IDLE_BELOW: cfg_r.tilt_idle_below <= pwdata[15:0];
        REG_TILT_BAND_LOW:   cfg_r.tilt_band_low   <= pwdata[15:0];
        REG_TILT_BAND_HIGH:  cfg_r.tilt_band_high  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux, signed fields come back sign extended
  always_comb begin
    unique case (reg_idx)
      REG_STEP_MARGIN:     prdata = {16'b0, cfg_r.step_margin};
      REG_MIN_INTERVAL_MS: prdata = {16'b0, cfg_r.min_interval_ms};
      REG_TILT_IDLE_BELOW: prdata = {{16{cfg_r.tilt_idle_below[15]}}, cfg_r.tilt_idle_below};
      REG_TILT_BAND_LOW:   prdata = {{16{cfg_r.tilt_band_low[15]}}, cfg_r.tilt_band_low};
      REG_TILT_BAND_HIGH:  prdata = {{16{cfg_r.tilt_band_high[15]}}, cfg_r.tilt_band_high};
      default:             prdata = 32'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/accel_step_detector_top.sv =====
`default_nettype none
`include "accel_step_detector_top_macros.svh"

// channel   | handshake             | payload
// ----------+-----------------------+--------------------------------------
// input     | in_valid / in_ready   | in_data   (asd_pkg::in_item_t)
// result    | out_valid / out_ready | out_data  (asd_pkg::out_item_t)
// config    | psel/penable/pwrite   | paddr, pwdata, prdata (pready high)
//
// a sample item passes from accept to result through the squaring steps on the
// shared 18x18 multiplier, the bit-serial root steps, a ring update and a decision
// a clear item goes straight to the decision stage
// in_ready is high only while idle, so no item is taken until the last one is done
// a waiting result holds the decision stage, and no new item is taken meanwhile
// synchronous active-low reset clears the ring, counters, LEDs and registers

module accel_step_detector_top #(
  parameter int WINDOW_DEPTH = 5
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire asd_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output asd_pkg::out_item_t                  out_data,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [asd_pkg::REG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import asd_pkg::*;

  localparam int POS_W  = $clog2(WINDOW_DEPTH);
  localparam int SUM_W  = MAG_W + $clog2(WINDOW_DEPTH);
  localparam int PROD_W = 2 * MUL_W;
  localparam int CNT_W  = $clog2(ROOT_STEPS);

  localparam logic [POS_W-1:0]        POS_LAST  = POS_W'(WINDOW_DEPTH - 1);
  localparam logic signed [MUL_W-1:0] DEPTH_OP  = MUL_W'(WINDOW_DEPTH);
  localparam logic [CNT_W-1:0]        SQ_LAST   = CNT_W'(3);
  localparam logic [CNT_W-1:0]        ROOT_LAST = CNT_W'(ROOT_STEPS - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_ROOT = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_DEC  = 3'd4;

  cfg_t cfg;

  // register file
  asd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // control state
  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             filled_r, filled_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [MAG_W-1:0] ring_r [WINDOW_DEPTH];
  logic [MAG_W-1:0] ring_nxt [WINDOW_DEPTH];
  logic [31:0]      last_ms_r, last_ms_nxt;
  logic [31:0]      total_r, total_nxt;
  logic             green_r, green_nxt;
  logic             red_r, red_nxt;
  logic             out_valid_r, out_valid_nxt;

  // datapath
  in_item_t                  item_r, item_nxt;
  logic [ACC_W-1:0]          acc_r, acc_nxt;
  logic [REM_W-1:0]          rem_r, rem_nxt;
  logic [MAG_W-1:0]          root_r, root_nxt;
  logic signed [PROD_W-1:0]  prod_r;
  logic                      time_ok_r, time_ok_nxt;
  out_item_t                 out_r, out_nxt;

  logic                      slot_free;
  logic                      in_acc;
  logic                      dec_go;
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [MUL_W-1:0]   excess_op;
  logic [REM_W+1:0]          rem_sh;
  logic [REM_W+1:0]          trial;
  logic [REM_W+1:0]          rem_sub;
  logic                      root_ge;
  logic                      excess_hit;
  logic                      step_hit;
  logic                      tilt_green;
  logic                      tilt_red;
  logic [1:0]                tilt_level;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign dec_go    = (state_r == ST_DEC) && slot_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // shared multiplier operands: squares of the axes, then excess times depth,
  // kept on the excess while the decision waits
  assign excess_op = $signed({2'b00, root_r}) - $signed({2'b00, cfg.step_margin});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_UPD || state_r == ST_DEC) begin
      mul_a = excess_op;
      mul_b = DEPTH_OP;
    end else if (state_r == ST_SQ) begin
      unique case (cnt_r[1:0])
        2'd0: begin
          mul_a = MUL_W'(item_r.accel_x);
          mul_b = MUL_W'(item_r.accel_x);
        end
        2'd1: begin
          mul_a = MUL_W'(item_r.accel_y);
          mul_b = MUL_W'(item_r.accel_y);
        end
        2'd2: begin
          mul_a = MUL_W'(item_r.accel_z);
          mul_b = MUL_W'(item_r.accel_z);
        end
        default: ;
      endcase
    end
  end

  // one step of the restoring square root: two radicand bits in, one root bit out
  assign rem_sh  = {rem_r, acc_r[ACC_W-1:ACC_W-2]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign root_ge = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  // (mag - thr) * depth > sum is the same as (mag - mean) > thr
  assign excess_hit = prod_r > $signed({{(PROD_W-SUM_W){1'b0}}, sum_r});
  assign step_hit   = filled_r && excess_hit && time_ok_r;

  // tilt bands, first match wins
  always_comb begin
    if (item_r.accel_y < cfg.tilt_idle_below) begin
      tilt_green = 1'b0; tilt_red = 1'b0; tilt_level = LEVEL_IDLE;
    end else if (item_r.accel_y < cfg.tilt_band_low) begin
      tilt_green = 1'b0; tilt_red = 1'b1; tilt_level = LEVEL_SINGLE;
    end else if (item_r.accel_y < cfg.tilt_band_high) begin
      tilt_green = 1'b1; tilt_red = 1'b1; tilt_level = LEVEL_BOTH;
    end else begin
      tilt_green = 1'b1; tilt_red = 1'b0; tilt_level = LEVEL_SINGLE;
    end
  end

  // sequencer and next-state logic
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    filled_nxt    = filled_r;
    sum_nxt       = sum_r;
    ring_nxt      = ring_r;
    last_ms_nxt   = last_ms_r;
    total_nxt     = total_r;
    green_nxt     = green_r;
    red_nxt       = red_r;
    item_nxt      = item_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    time_ok_nxt   = time_ok_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          item_nxt = in_data;
          if (in_data.command) begin
            state_nxt = ST_DEC;
          end else begin
            acc_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = ST_SQ;
          end
        end
      end
      ST_SQ: begin
        if (cnt_r != '0) begin
          acc_nxt = acc_r + prod_r[ACC_W-1:0];
        end
        if (cnt_r == SQ_LAST) begin
          cnt_nxt   = '0;
          rem_nxt   = '0;
          root_nxt  = '0;
          state_nxt = ST_ROOT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_ROOT: begin
        rem_nxt  = root_ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
        root_nxt = {root_r[MAG_W-2:0], root_ge};
        acc_nxt  = {acc_r[ACC_W-3:0], 2'b00};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == ROOT_LAST) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        sum_nxt          = sum_r - SUM_W'(ring_r[pos_r]) + SUM_W'(root_r);
        ring_nxt[pos_r]  = root_r;
        if (pos_r == POS_LAST) begin
          pos_nxt    = '0;
          filled_nxt = 1'b1;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
        time_ok_nxt = (item_r.now_ms - last_ms_r) > {16'b0, cfg.min_interval_ms};
        state_nxt   = ST_DEC;
      end
      ST_DEC: begin
        if (slot_free) begin
          if (item_r.command) begin
            // clear item: zero the count, report current window and LEDs
            total_nxt            = 32'b0;
            out_nxt.step_count   = 32'b0;
            out_nxt.step_seen    = 1'b0;
            out_nxt.window_ready = filled_r;
            out_nxt.led_green    = green_r;
            out_nxt.led_red      = red_r;
            out_nxt.level_code   = LEVEL_IDLE;
          end else begin
            if (step_hit) begin
              last_ms_nxt = item_r.now_ms;
              total_nxt   = total_r + 1'b1;
            end
            if (filled_r) begin
              green_nxt = tilt_green;
              red_nxt   = tilt_red;
            end
            out_nxt.step_count   = step_hit ? total_r + 1'b1 : total_r;
            out_nxt.step_seen    = step_hit;
            out_nxt.window_ready = filled_r;
            out_nxt.led_green    = filled_r ? tilt_green : green_r;
            out_nxt.led_red      = filled_r ? tilt_red : red_r;
            out_nxt.level_code   = filled_r ? tilt_level : LEVEL_IDLE;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pos_r       <= '0;
      filled_r    <= 1'b0;
      sum_r       <= '0;
      last_ms_r   <= 32'b0;
      total_r     <= 32'b0;
      green_r     <= 1'b0;
      red_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        ring_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      filled_r    <= filled_nxt;
      sum_r       <= sum_nxt;
      last_ms_r   <= last_ms_nxt;
      total_r     <= total_nxt;
      green_r     <= green_nxt;
      red_r       <= red_nxt;
      out_valid_r <= out_valid_nxt;
      ring_r      <= ring_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    acc_r     <= acc_nxt;
    rem_r     <= rem_nxt;
    root_r    <= root_nxt;
    prod_r    <= mul_a * mul_b;
    time_ok_r <= time_ok_nxt;
    out_r     <= out_nxt;
  end

  // checks
  `ASD_ASSERT_NEXT(a_item_busy, in_acc, !in_ready, "accept did not leave idle")
  `ASD_ASSERT_NOW(a_pos_range, 1'b1, pos_r <= POS_LAST, "ring position past window depth")
  `ASD_ASSERT_NOW(a_step_needs_window, out_valid && out_data.step_seen, out_data.window_ready, "step reported before window filled")
  `ASD_ASSERT_NEXT(a_dec_delivers, dec_go, out_valid && state_r == ST_IDLE, "decision did not deliver a result")

endmodule

`default_nettype wire

// ===== tb/sv/accel_step_detector_top_test.sv =====
module accel_step_detector_top_test;
  import asd_pkg::*;

  localparam int WIN = 5;
  localparam int CYCLE_LIMIT = 300000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [REG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  accel_step_detector_top #(.WINDOW_DEPTH(WIN)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // pedometer state as the block should hold it
  cfg_t cfg_now = CFG_RESET;
  logic [15:0] mag_ring [WIN];
  int ring_pos;
  bit ring_full;
  logic [18:0] mag_sum;
  logic [31:0] last_step_ms;
  logic [31:0] steps;
  bit green_lit;
  bit red_lit;

  in_item_t samples_to_send [$];
  out_item_t expected_readings [$];
  int items_offered = 0;
  int items_taken = 0;
  bit in_took = 1'b0;
  int errors = 0;
  int cycles = 0;

  // pacing controls
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit rx_long_req = 1'b0;
  int tx_wait = 0;
  int rx_stall = 0;
  logic [31:0] walk_ms = 32'd2000;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] floor_root(logic [31:0] v);
    logic [15:0] r;
    logic [15:0] t;
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      t = r | (16'd1 << b);
      if (64'(t) * 64'(t) <= 64'(v)) r = t;
    end
    return r;
  endfunction

  // one sample or clear through the detector, returns the reading it yields
  function automatic out_item_t advance_pedometer(in_item_t it);
    out_item_t res;
    logic signed [15:0] y;
    int sx, sy, sz;
    logic [31:0] sq;
    logic [31:0] since_ms;
    logic [15:0] mag;
    longint excess;
    logic [1:0] lvl;
    bit seen;
    y = it.accel_y;
    seen = 1'b0;
    lvl = LEVEL_IDLE;
    if (it.command) begin
      steps = '0;
    end else begin
      sx = $signed(it.accel_x);
      sy = $signed(it.accel_y);
      sz = $signed(it.accel_z);
      sq = 32'(sx * sx) + 32'(sy * sy) + 32'(sz * sz);
      mag = floor_root(sq);
      mag_sum = mag_sum - 19'(mag_ring[ring_pos]) + 19'(mag);
      mag_ring[ring_pos] = mag;
      if (ring_pos == WIN - 1) begin
        ring_pos = 0;
        ring_full = 1'b1;
      end else begin
        ring_pos++;
      end
      if (ring_full) begin
        excess = longint'(mag) - longint'(mag_sum / WIN);
        since_ms = it.now_ms - last_step_ms;
        if (excess > longint'(cfg_now.step_margin) &&
            since_ms > 32'(cfg_now.min_interval_ms)) begin
          last_step_ms = it.now_ms;
          steps++;
          seen = 1'b1;
        end
        // tilt bands, first match wins
        if (y < $signed(cfg_now.tilt_idle_below)) begin
          green_lit = 1'b0; red_lit = 1'b0; lvl = LEVEL_IDLE;
        end else if (y < $signed(cfg_now.tilt_band_low)) begin
          green_lit = 1'b0; red_lit = 1'b1; lvl = LEVEL_SINGLE;
        end else if (y < $signed(cfg_now.tilt_band_high)) begin
          green_lit = 1'b1; red_lit = 1'b1; lvl = LEVEL_BOTH;
        end else begin
          green_lit = 1'b1; red_lit = 1'b0; lvl = LEVEL_SINGLE;
        end
      end
    end
    res.step_count = steps;
    res.step_seen = seen;
    res.window_ready = ring_full;
    res.led_green = green_lit;
    res.led_red = red_lit;
    res.level_code = lvl;
    return res;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
    errors++;
  endtask

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  // result check and input prediction, sampled at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took = 1'b0;
    end else if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      cycles++;
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          flag_mismatch("reading with none pending", out_data, 0);
        end else begin
          out_item_t want;
          want = expected_readings.pop_front();
          if (out_data.step_count !== want.step_count)
            flag_mismatch("step_count", out_data.step_count, want.step_count);
          if (out_data.step_seen !== want.step_seen)
            flag_mismatch("step_seen", out_data.step_seen, want.step_seen);
          if (out_data.window_ready !== want.window_ready)
            flag_mismatch("window_ready", out_data.window_ready, want.window_ready);
          if (out_data.led_green !== want.led_green)
            flag_mismatch("led_green", out_data.led_green, want.led_green);
          if (out_data.led_red !== want.led_red)
            flag_mismatch("led_red", out_data.led_red, want.led_red);
          if (out_data.level_code !== want.level_code)
            flag_mismatch("level_code", out_data.level_code, want.level_code);
        end
      end
      in_took = in_valid && in_ready;
      if (in_took) begin
        expected_readings.push_back(advance_pedometer(in_data));
        items_taken++;
      end
    end
  end

  // sample driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else if (!in_valid || in_took) begin
      if (tx_wait > 0) begin
        in_valid <= 1'b0;
        tx_wait--;
      end else if (samples_to_send.size() > 0) begin
        in_data <= samples_to_send.pop_front();
        in_valid <= 1'b1;
        items_offered++;
        tx_wait = pick_gap(tx_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // reading receiver with random stalls and one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_long_req) begin
        rx_stall = 300;
        rx_long_req = 1'b0;
      end
      if (rx_stall > 0) begin
        out_ready <= 1'b0;
        rx_stall--;
      end else begin
        out_ready <= 1'b1;
        rx_stall = pick_gap(rx_calm);
      end
    end
  end

  // register write followed by a read back
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [15:0] value);
    logic [31:0] rd;
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[15:0] !== value) flag_mismatch("register read back", rd[15:0], value);
    case (idx)
      REG_STEP_MARGIN:     cfg_now.step_margin = value;
      REG_MIN_INTERVAL_MS: cfg_now.min_interval_ms = value;
      REG_TILT_IDLE_BELOW: cfg_now.tilt_idle_below = value;
      REG_TILT_BAND_LOW:   cfg_now.tilt_band_low = value;
      REG_TILT_BAND_HIGH:  cfg_now.tilt_band_high = value;
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [15:0] thr, logic [15:0] min_ms,
                                logic [15:0] idle_y, logic [15:0] low_y,
                                logic [15:0] high_y);
    write_reg(REG_STEP_MARGIN, thr);
    write_reg(REG_MIN_INTERVAL_MS, min_ms);
    write_reg(REG_TILT_IDLE_BELOW, idle_y);
    write_reg(REG_TILT_BAND_LOW, low_y);
    write_reg(REG_TILT_BAND_HIGH, high_y);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (samples_to_send.size() != 0 || items_offered != items_taken ||
           expected_readings.size() != 0);
  endtask

  task automatic send_sample(int x, int y, int z, logic [31:0] t);
    in_item_t it;
    it.command = 1'b0;
    it.accel_x = 16'(x);
    it.accel_y = 16'(y);
    it.accel_z = 16'(z);
    it.now_ms = t;
    samples_to_send.push_back(it);
  endtask

  // arbitrary field values, either a sample or a clear
  function automatic in_item_t random_item(bit clear);
    in_item_t it;
    it.command = clear;
    it.accel_x = 16'($urandom);
    it.accel_y = 16'($urandom);
    it.accel_z = 16'($urandom);
    it.now_ms = $urandom;
    return it;
  endfunction

  // walking motion: mostly about 1 g on y, random impacts on z, rising time
  function automatic in_item_t walk_item();
    in_item_t it;
    walk_ms += 32'($urandom_range(8, 60));
    if ($urandom_range(0, 19) == 0) walk_ms += 32'($urandom_range(300, 1500));
    it.command = 1'b0;
    it.accel_x = 16'(int'($urandom_range(0, 1200)) - 600);
    it.accel_z = 16'(int'($urandom_range(0, 1200)) - 600);
    if ($urandom_range(0, 4) == 0) it.accel_z = 16'(int'($urandom_range(6000, 14000)));
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 2))
        0: it.accel_y = cfg_now.tilt_idle_below - 16'($urandom_range(0, 1));
        1: it.accel_y = cfg_now.tilt_band_low - 16'($urandom_range(0, 1));
        default: it.accel_y = cfg_now.tilt_band_high - 16'($urandom_range(0, 1));
      endcase
    end else begin
      it.accel_y = 16'(int'($urandom_range(3500, 4700)));
    end
    it.now_ms = walk_ms;
    return it;
  endfunction

  task automatic feed_mix(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 78) samples_to_send.push_back(walk_item());
      else if (r < 92) samples_to_send.push_back(random_item(1'b0));
      else samples_to_send.push_back(random_item(1'b1));
    end
  endtask

  initial begin
    mag_ring = '{default: '0};
    ring_pos = 0;
    ring_full = 1'b0;
    mag_sum = '0;
    last_step_ms = '0;
    steps = '0;
    green_lit = 1'b0;
    red_lit = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed: clear before fill, axis extremes, fill, steps, bands, wrap
    samples_to_send.push_back(random_item(1'b1));
    send_sample(-32768, -32768, -32768, 32'd0);
    send_sample(32767, 32767, 32767, 32'd10);
    send_sample(0, 0, 0, 32'd20);
    send_sample(-32768, 32767, 0, 32'd30);
    send_sample(0, 4096, 0, 32'd40);
    send_sample(0, 4096, 0, 32'd100);
    send_sample(0, 20000, 0, 32'd1000);
    send_sample(0, 20000, 0, 32'd1200);
    send_sample(0, 24000, 0, 32'd1601);
    send_sample(0, 0, 4096, 32'd1700);
    send_sample(0, 1, 4096, 32'd1710);
    send_sample(0, 2047, 4096, 32'd1720);
    send_sample(0, 2048, 4096, 32'd1730);
    send_sample(0, 2252, 4096, 32'd1740);
    send_sample(0, 2253, 4096, 32'd1750);
    send_sample(0, -32768, 0, 32'hFFFF_FF00);
    send_sample(32767, 0, 0, 32'h0000_0100);
    samples_to_send.push_back(random_item(1'b1));
    send_sample(0, 4096, 0, 32'h0000_0300);
    send_sample(0, -1, 0, 32'h0000_0310);
    send_sample(0, 32767, 0, 32'h0000_0320);
    feed_mix(100);
    wait_drained();

    // typical settings, receiver holds off while samples keep coming
    apply_settings(16'd800, 16'd200, -16'sd1000, 16'sd1000, 16'sd3000);
    tx_calm = 1'b1;
    feed_mix(80);
    @(posedge clk);
    rx_long_req = 1'b1;
    wait_drained();
    tx_calm = 1'b0;

    // lowest threshold and interval, no idling on either side
    apply_settings(16'd0, 16'd0, 16'sh8000, 16'sd0, 16'sh7FFF);
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    feed_mix(70);
    wait_drained();
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    // highest threshold and interval, bands out of order
    apply_settings(16'hFFFF, 16'hFFFF, 16'sh7FFF, 16'sh8000, 16'sd0);
    feed_mix(50);
    wait_drained();

    // small threshold, time crossing the wrap, sender pause midway
    apply_settings(16'd100, 16'd50, 16'sd0, 16'sd3000, 16'sd1000);
    walk_ms = 32'hFFFF_F000;
    feed_mix(40);
    wait_drained();
    feed_mix(60);
    wait_drained();

    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/asd_pkg.sv
sv/asd_regs.sv
sv/accel_step_detector_top.sv
tb/sv/accel_step_detector_top_test.sv
